// ===== src/wall_force_quadrature_defines.svh =====
// Assertion macros shared by the checker file of the wall force block.
`ifndef WALL_FORCE_QUADRATURE_DEFINES_SVH
`define WALL_FORCE_QUADRATURE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define WFQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off while rst is high.
`define WFQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/wfq_pkg.sv =====
// Shared types, constants and helper functions of the wall force block.
package wfq_pkg;

  localparam int FRAC_BITS = 16;
  localparam int W_BITS    = 30;
  localparam int MAX_ORDER = 6;

  localparam int IN_DATA_W  = 264;
  localparam int OUT_DATA_W = 96;

  localparam logic [30:0] SQRT2_Q30 = 31'd1518500250;

  // register indexes on the configuration port
  localparam logic CFG_GAS_RT     = 1'b0;
  localparam logic CFG_POLY_ORDER = 1'b1;

  typedef logic signed [47:0] sum_t;

  localparam sum_t SUM_MAX = {1'b0, {47{1'b1}}};
  localparam sum_t SUM_MIN = {1'b1, {47{1'b0}}};

  typedef enum logic [1:0] {
    MODE_EXACT,
    MODE_FRAC,
    MODE_WGT
  } mul_mode_t;

  typedef struct packed {
    logic      go;
    mul_mode_t mode;
  } mul_req_t;

  // Add or subtract two 48-bit values and clamp to the 48-bit range.
  function automatic sum_t sat_addsub(sum_t a, sum_t b, logic sub);
    logic signed [48:0] s;
    s = sub ? ({a[47], a} - {b[47], b}) : ({a[47], a} + {b[47], b});
    if (s[48] != s[47]) begin
      return s[48] ? SUM_MIN : SUM_MAX;
    end
    return s[47:0];
  endfunction

  // Gauss-Lobatto face weight, unsigned Q.30; zero past the order or out of range.
  function automatic logic [30:0] gl_weight(logic [2:0] order, logic [2:0] node);
    logic [30:0] w;
    w = '0;
    if (order >= 3'd1 && 32'(order) <= MAX_ORDER && node <= order) begin
      case ({order, node}) inside
        6'o10, 6'o11: w = 31'd1073741824;
        6'o20, 6'o22: w = 31'd357913941;
        6'o21:        w = 31'd1431655765;
        6'o30, 6'o33: w = 31'd178956971;
        6'o31, 6'o32: w = 31'd894784853;
        6'o40, 6'o44: w = 31'd107374182;
        6'o41, 6'o43: w = 31'd584592771;
        6'o42:        w = 31'd763549742;
        6'o50, 6'o55: w = 31'd71582788;
        6'o51, 6'o54: w = 31'd406384390;
        6'o52, 6'o53: w = 31'd595774646;
        6'o60, 6'o66: w = 31'd51130563;
        6'o61, 6'o65: w = 31'd297239705;
        6'o62, 6'o64: w = 31'd463583073;
        6'o63:        w = 31'd523576966;
        default:      w = '0;
      endcase
    end
    return w;
  endfunction

endpackage

// ===== src/wall_force_quadrature.sv =====
// Top level: wall force quadrature over face nodes with running saturating sums.
//
//   channel | dir | beat
//   s_*     | in  | one face node: moments, normal, Jacobian, node index
//   m_*     | out | running force sums and zero-density flag
//   cfg_*   | in  | register write: 0 gas_rt, 1 poly_order
//
// A node with nonzero density runs three exact products, each followed by a
// divide by rho, and twelve rounded products, all through one bit-serial
// multiplier and one bit-serial divider. A zero-density node skips the
// arithmetic. One node is in flight at a time; the next node is taken while
// a finished beat still waits on m_tready.
// rst clears the sums and m_tvalid, and returns the registers to their defaults.
module wall_force_quadrature import wfq_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // node_index[2:0], rho, mom_x, mom_y, mom_xy, mom_xx, mom_yy, normal_x,
  // normal_y, surf_jacobian[261:231], zero pad
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // start_sum
  input  logic                  s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // force_x[47:0], force_y[95:48]
  output logic [OUT_DATA_W-1:0] m_tdata,
  // zero_density
  output logic                  m_tuser,
  input  logic                  cfg_we,
  input  logic                  cfg_index,
  input  logic [30:0]           cfg_data
);

  typedef enum logic [2:0] {T_IDLE, T_ISSUE, T_WMUL, T_WDIV, T_FIN} tstate_t;

  localparam logic [3:0] STEP_LAST_DIV = 4'd2;
  localparam logic [3:0] STEP_ADD      = 4'd5;
  localparam logic [3:0] STEP_LAST     = 4'd15;

  tstate_t state;
  logic [3:0] step;

  logic [30:0] gas_rt;
  logic [2:0]  poly_order;

  logic signed [31:0] q1, q2, q3, q4, q5, q6;
  logic signed [17:0] nx, ny;
  logic [30:0]        sj;
  logic [30:0]        w;

  sum_t t1, t2, t3, a11, a22, i12, gx, gy;
  sum_t sum_x, sum_y;
  logic flag;

  sum_t force_x, force_y;
  logic zero_density;

  mul_req_t           mul_req;
  sum_t               mul_a;
  logic signed [32:0] mul_b;
  mul_mode_t          mul_mode;
  logic               mul_done;
  sum_t               mul_res;
  logic               mul_neg;
  logic [62:0]        mul_mag;

  logic div_go;
  logic div_done;
  sum_t div_quo;

  logic in_beat;

  assign in_beat  = s_tvalid && s_tready;
  assign s_tready = (state == T_IDLE) && !rst;
  assign m_tdata  = {force_y, force_x};
  assign m_tuser  = zero_density;

  // Operand selection for each sequencer step.
  always_comb begin
    mul_a    = '0;
    mul_b    = '0;
    mul_mode = MODE_FRAC;
    case (step)
      4'd0:  begin mul_a = sum_t'(q2); mul_b = 33'(q2); mul_mode = MODE_EXACT; end
      4'd1:  begin mul_a = sum_t'(q2); mul_b = 33'(q3); mul_mode = MODE_EXACT; end
      4'd2:  begin mul_a = sum_t'(q3); mul_b = 33'(q3); mul_mode = MODE_EXACT; end
      4'd3:  begin mul_a = sum_t'(q5); mul_b = {2'b00, SQRT2_Q30}; mul_mode = MODE_WGT; end
      4'd4:  begin mul_a = sum_t'(q6); mul_b = {2'b00, SQRT2_Q30}; mul_mode = MODE_WGT; end
      4'd6:  begin mul_a = a11; mul_b = 33'(nx); end
      4'd7:  begin mul_a = i12; mul_b = 33'(ny); end
      4'd8:  begin mul_a = a22; mul_b = 33'(ny); end
      4'd9:  begin mul_a = i12; mul_b = 33'(nx); end
      4'd10: begin mul_a = gx;  mul_b = {2'b00, gas_rt}; end
      4'd11: begin mul_a = gx;  mul_b = {2'b00, sj}; end
      4'd12: begin mul_a = gx;  mul_b = {2'b00, w}; mul_mode = MODE_WGT; end
      4'd13: begin mul_a = gy;  mul_b = {2'b00, gas_rt}; end
      4'd14: begin mul_a = gy;  mul_b = {2'b00, sj}; end
      4'd15: begin mul_a = gy;  mul_b = {2'b00, w}; mul_mode = MODE_WGT; end
      default: begin mul_a = '0; mul_b = '0; mul_mode = MODE_FRAC; end
    endcase
    mul_req.go   = (state == T_ISSUE) && (step != STEP_ADD);
    mul_req.mode = mul_mode;
  end

  assign div_go = (state == T_WMUL) && mul_done && (step <= STEP_LAST_DIV);

  wfq_mul u_mul (
    .clk  (clk),
    .rst  (rst),
    .req  (mul_req),
    .a    (mul_a),
    .b    (mul_b),
    .done (mul_done),
    .res  (mul_res),
    .neg  (mul_neg),
    .mag  (mul_mag)
  );

  wfq_div u_div (
    .clk     (clk),
    .rst     (rst),
    .go      (div_go),
    .num     (mul_mag),
    .num_neg (mul_neg),
    .den     (q1),
    .done    (div_done),
    .quo     (div_quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= T_IDLE;
      step       <= '0;
      gas_rt     <= 31'd65536;
      poly_order <= 3'd1;
      sum_x      <= '0;
      sum_y      <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_GAS_RT:     gas_rt     <= cfg_data;
          CFG_POLY_ORDER: poly_order <= cfg_data[2:0];
          default:        ;
        endcase
      end
      // drop valid once taken, unless a fresh beat is loaded in the same cycle
      if (m_tvalid && m_tready && state != T_FIN) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        T_IDLE: begin
          if (in_beat) begin
            q1 <= s_tdata[34:3];
            q2 <= s_tdata[66:35];
            q3 <= s_tdata[98:67];
            q4 <= s_tdata[130:99];
            q5 <= s_tdata[162:131];
            q6 <= s_tdata[194:163];
            nx <= s_tdata[212:195];
            ny <= s_tdata[230:213];
            sj <= s_tdata[261:231];
            w  <= gl_weight(poly_order, s_tdata[2:0]);
            if (s_tuser) begin
              sum_x <= '0;
              sum_y <= '0;
            end
            step <= '0;
            // skip the node entirely on zero density
            if (s_tdata[34:3] == 32'd0) begin
              flag  <= 1'b1;
              state <= T_FIN;
            end else begin
              flag  <= 1'b0;
              state <= T_ISSUE;
            end
          end
        end
        T_ISSUE: begin
          if (step == STEP_ADD) begin
            a11  <= sat_addsub(sum_t'(q1), a11, 1'b0);
            a22  <= sat_addsub(sum_t'(q1), a22, 1'b0);
            i12  <= sat_addsub(sum_t'(q4), t2, 1'b1);
            step <= step + 4'd1;
          end else begin
            state <= T_WMUL;
          end
        end
        T_WMUL: begin
          if (mul_done) begin
            if (step <= STEP_LAST_DIV) begin
              state <= T_WDIV;
            end else begin
              case (step) inside
                4'd3:    a11   <= sat_addsub(mul_res, t1, 1'b1);
                4'd4:    a22   <= sat_addsub(mul_res, t3, 1'b1);
                4'd6:    gx    <= mul_res;
                4'd7:    gx    <= sat_addsub(gx, mul_res, 1'b0);
                4'd8:    gy    <= mul_res;
                4'd9:    gy    <= sat_addsub(gy, mul_res, 1'b0);
                4'd10,
                4'd11:   gx    <= mul_res;
                4'd12:   sum_x <= sat_addsub(sum_x, mul_res, 1'b0);
                4'd13,
                4'd14:   gy    <= mul_res;
                4'd15:   sum_y <= sat_addsub(sum_y, mul_res, 1'b0);
                default: ;
              endcase
              if (step == STEP_LAST) begin
                state <= T_FIN;
              end else begin
                step  <= step + 4'd1;
                state <= T_ISSUE;
              end
            end
          end
        end
        T_WDIV: begin
          if (div_done) begin
            case (step)
              4'd0:    t1 <= div_quo;
              4'd1:    t2 <= div_quo;
              default: t3 <= div_quo;
            endcase
            step  <= step + 4'd1;
            state <= T_ISSUE;
          end
        end
        T_FIN: begin
          // hold until the previous beat has gone
          if (!m_tvalid || m_tready) begin
            force_x      <= sum_x;
            force_y      <= sum_y;
            zero_density <= flag;
            m_tvalid     <= 1'b1;
            state        <= T_IDLE;
          end
        end
        default: state <= T_IDLE;
      endcase
    end
  end

endmodule

// ===== src/wfq_mul.sv =====
// Bit-serial shift-add multiplier; the rounded modes saturate to 48 bits.
module wfq_mul import wfq_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  mul_req_t           req,
  input  sum_t               a,
  input  logic signed [32:0] b,
  output logic               done,
  output sum_t               res,
  output logic               neg,
  output logic [62:0]        mag
);

  typedef enum logic [1:0] {M_IDLE, M_RUN, M_RND, M_SAT} mstate_t;

  mstate_t     state;
  mul_mode_t   mode;
  logic [47:0] am;
  logic [31:0] bm;
  logic [79:0] acc;
  logic [80:0] rnd;
  logic [4:0]  cnt;

  logic [48:0] upper;
  logic [80:0] half;
  logic [80:0] shifted;
  logic [80:0] lim;
  logic [47:0] mag48;

  always_comb begin
    upper = {1'b0, acc[79:32]} + (bm[0] ? {1'b0, am} : 49'd0);
    case (mode)
      MODE_FRAC: begin
        half    = 81'(1) << (FRAC_BITS - 1);
        shifted = rnd >> FRAC_BITS;
      end
      default: begin
        half    = 81'(1) << (W_BITS - 1);
        shifted = rnd >> W_BITS;
      end
    endcase
    lim   = neg ? (81'(1) << 47) : ((81'(1) << 47) - 81'd1);
    mag48 = (shifted > lim) ? lim[47:0] : shifted[47:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= M_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        M_IDLE: begin
          if (req.go) begin
            mode  <= req.mode;
            am    <= a[47] ? 48'(-a) : 48'(a);
            bm    <= b[32] ? 32'(-b) : b[31:0];
            neg   <= a[47] ^ b[32];
            acc   <= '0;
            cnt   <= '0;
            state <= M_RUN;
          end
        end
        M_RUN: begin
          acc <= {upper, acc[31:1]};
          bm  <= bm >> 1;
          cnt <= cnt + 5'd1;
          if (cnt == 5'd31) begin
            state <= M_RND;
          end
        end
        M_RND: begin
          if (mode == MODE_EXACT) begin
            mag   <= acc[62:0];
            done  <= 1'b1;
            state <= M_IDLE;
          end else begin
            rnd   <= {1'b0, acc} + half;
            state <= M_SAT;
          end
        end
        M_SAT: begin
          res   <= neg ? sum_t'(48'd0 - mag48) : sum_t'(mag48);
          done  <= 1'b1;
          state <= M_IDLE;
        end
        default: state <= M_IDLE;
      endcase
    end
  end

endmodule

// ===== src/wfq_div.sv =====
// Radix-2 restoring divider, truncating toward zero, 48-bit saturated quotient.
module wfq_div import wfq_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               go,
  input  logic [62:0]        num,
  input  logic               num_neg,
  input  logic signed [31:0] den,
  output logic               done,
  output sum_t               quo
);

  typedef enum logic [1:0] {D_IDLE, D_RUN, D_SAT} dstate_t;

  dstate_t     state;
  logic [62:0] nq;
  logic [31:0] rem;
  logic [31:0] dm;
  logic [5:0]  cnt;
  logic        neg;

  logic [32:0] r2;
  logic [32:0] diff;
  logic        ge;
  logic [62:0] lim;
  logic [47:0] mag48;

  always_comb begin
    r2    = {rem, nq[62]};
    diff  = r2 - {1'b0, dm};
    ge    = (r2 >= {1'b0, dm});
    lim   = neg ? (63'(1) << 47) : ((63'(1) << 47) - 63'd1);
    mag48 = (nq > lim) ? lim[47:0] : nq[47:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= D_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        D_IDLE: begin
          if (go) begin
            nq    <= num;
            rem   <= '0;
            dm    <= den[31] ? 32'(-den) : 32'(den);
            neg   <= num_neg ^ den[31];
            cnt   <= '0;
            state <= D_RUN;
          end
        end
        D_RUN: begin
          rem <= ge ? diff[31:0] : r2[31:0];
          nq  <= {nq[61:0], ge};
          cnt <= cnt + 6'd1;
          if (cnt == 6'd62) begin
            state <= D_SAT;
          end
        end
        D_SAT: begin
          quo   <= neg ? sum_t'(48'd0 - mag48) : sum_t'(mag48);
          done  <= 1'b1;
          state <= D_IDLE;
        end
        default: state <= D_IDLE;
      endcase
    end
  end

endmodule

// ===== src/wfq_check.sv =====
// Port-level checker for the wall force block, bound to the top level.
`include "wall_force_quadrature_defines.svh"

module wfq_check (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [95:0] m_tdata
);

  `WFQ_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled result beat changed")
  `WFQ_ASSERT_NEXT(a_one_node, s_tvalid && s_tready, !s_tready, "second node taken while one is in flight")
  `WFQ_ASSERT_NOW(a_result_cause, $rose(m_tvalid), $past(!s_tready), "result beat without a node in flight")

endmodule

bind wall_force_quadrature wfq_check u_wfq_check (.*);

// ===== tb/wall_force_quadrature_tb.sv =====
// Testbench for wall_force_quadrature: stream stimulus, a force-sum predictor and a result check.
`timescale 1ns / 100ps

module wall_force_quadrature_tb import wfq_pkg::*;;

  localparam int   HOLD_LEN   = 3000;
  localparam int   SETTLE     = 1000;

  localparam longint GL_W [0:6][0:6] = '{
    '{0, 0, 0, 0, 0, 0, 0},
    '{1073741824, 1073741824, 0, 0, 0, 0, 0},
    '{357913941, 1431655765, 357913941, 0, 0, 0, 0},
    '{178956971, 894784853, 894784853, 178956971, 0, 0, 0},
    '{107374182, 584592771, 763549742, 584592771, 107374182, 0, 0},
    '{71582788, 406384390, 595774646, 595774646, 406384390, 71582788, 0},
    '{51130563, 297239705, 463583073, 523576966, 463583073, 297239705, 51130563}
  };

  typedef struct {
    logic               start;
    logic [2:0]         node;
    logic signed [31:0] rho, mx, my, mxy, mxx, myy;
    logic signed [17:0] nx, ny;
    logic [30:0]        sj;
  } node_t;

  typedef struct {
    sum_t fx;
    sum_t fy;
    logic zd;
  } force_t;

  function automatic longint clamp48(longint v);
    if (v > longint'(SUM_MAX)) return longint'(SUM_MAX);
    if (v < longint'(SUM_MIN)) return longint'(SUM_MIN);
    return v;
  endfunction

  // Exact product, rounded half away from zero on the shift, clamped to 48 bits.
  function automatic longint mul_round(longint a, longint b, int sh);
    logic        neg;
    logic [63:0] ua, ub;
    logic [127:0] m, lim;
    neg = (a < 0) != (b < 0);
    ua = a < 0 ? -a : a;
    ub = b < 0 ? -b : b;
    m = {64'd0, ua} * {64'd0, ub};
    m = (m + (128'd1 << (sh - 1))) >> sh;
    lim = neg ? (128'd1 << 47) : ((128'd1 << 47) - 128'd1);
    if (m > lim) m = lim;
    return neg ? -longint'(m[63:0]) : longint'(m[63:0]);
  endfunction

  class force_board;
    force_t      pending[$];
    longint      acc_x, acc_y;
    longint      rt;
    int unsigned order;
    int          fails;

    function new();
      acc_x = 0; acc_y = 0; rt = 65536; order = 1; fails = 0;
    endfunction

    function void write_reg(logic idx, logic [30:0] v);
      if (idx == CFG_GAS_RT) rt = longint'(v);
      else order = v[2:0];
    endfunction

    function void note(node_t n);
      force_t e;
      longint q1, q2, q3, w, i11, i12, i22, gx, gy, fx, fy;
      q1 = n.rho; q2 = n.mx; q3 = n.my;
      w = 0;
      if (n.start) begin
        acc_x = 0; acc_y = 0;
      end
      e.zd = (q1 == 0);
      if (!e.zd) begin
        if (order >= 1 && order <= MAX_ORDER && n.node <= order) w = GL_W[order][n.node];
        i11 = clamp48(mul_round(longint'(n.mxx), SQRT2_Q30, W_BITS) - clamp48(q2 * q2 / q1));
        i12 = clamp48(longint'(n.mxy) - clamp48(q2 * q3 / q1));
        i22 = clamp48(mul_round(longint'(n.myy), SQRT2_Q30, W_BITS) - clamp48(q3 * q3 / q1));
        gx = clamp48(mul_round(clamp48(q1 + i11), n.nx, FRAC_BITS)
                     + mul_round(i12, n.ny, FRAC_BITS));
        gy = clamp48(mul_round(clamp48(q1 + i22), n.ny, FRAC_BITS)
                     + mul_round(i12, n.nx, FRAC_BITS));
        fx = mul_round(mul_round(mul_round(gx, rt, FRAC_BITS), n.sj, FRAC_BITS), w, W_BITS);
        fy = mul_round(mul_round(mul_round(gy, rt, FRAC_BITS), n.sj, FRAC_BITS), w, W_BITS);
        acc_x = clamp48(acc_x + fx);
        acc_y = clamp48(acc_y + fy);
      end
      e.fx = acc_x[47:0];
      e.fy = acc_y[47:0];
      pending.push_back(e);
    endfunction

    function void check(logic [OUT_DATA_W-1:0] d, logic zd);
      force_t e;
      if (pending.size() == 0) begin
        fails++;
        if (fails <= 10) $display("unexpected beat: fx=%0d fy=%0d zd=%0b",
                                  $signed(d[47:0]), $signed(d[95:48]), zd);
        return;
      end
      e = pending.pop_front();
      if (d[47:0] !== e.fx || d[95:48] !== e.fy || zd !== e.zd) begin
        fails++;
        if (fails <= 10)
          $display("mismatch: fx exp %0d got %0d, fy exp %0d got %0d, zd exp %0b got %0b",
                   e.fx, $signed(d[47:0]), e.fy, $signed(d[95:48]), e.zd, zd);
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic                  s_tuser = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  m_tuser;
  logic                  cfg_we = 1'b0;
  logic                  cfg_index = 1'b0;
  logic [30:0]           cfg_data = '0;

  force_board board = new();
  int  snd_idle = 0, rcv_idle = 0;
  bit  want_hold = 0;
  int  hold_left = 0;

  wall_force_quadrature dut (.*);

  always #4 clk = ~clk;

  initial begin
    #(64'd40_000_000);
    $display("== FAIL ==");
    $finish;
  end

  // Receiver: check accepted beats, then draw the next ready.
  initial begin
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) board.check(m_tdata, m_tuser);
      if (want_hold) begin
        hold_left = HOLD_LEN;
        want_hold = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= rcv_idle);
      end
    end
  end

  function automatic logic [IN_DATA_W-1:0] pack_node(node_t n);
    return {2'b00, n.sj, n.ny, n.nx, n.myy, n.mxx, n.mxy, n.my, n.mx, n.rho, n.node};
  endfunction

  function automatic logic signed [17:0] rand_normal();
    return 18'(int'($urandom_range(131072)) - 65536);
  endfunction

  function automatic logic signed [31:0] rand_moment();
    if ($urandom_range(9) == 0) return $urandom;
    return 32'(int'($urandom_range(1 << 20)) - (1 << 19));
  endfunction

  function automatic node_t rand_node(logic start, logic [2:0] idx);
    node_t n;
    n.start = start; n.node = idx;
    n.rho = $urandom_range(1 << 18, 1 << 14);
    if ($urandom_range(9) == 0) n.rho = -n.rho;
    if ($urandom_range(19) == 0) n.rho = 0;
    if ($urandom_range(19) == 0) n.rho = $urandom;
    n.mx = rand_moment(); n.my = rand_moment(); n.mxy = rand_moment();
    n.mxx = rand_moment(); n.myy = rand_moment();
    n.nx = rand_normal(); n.ny = rand_normal();
    n.sj = ($urandom_range(9) == 0) ? 31'($urandom) : 31'($urandom_range(1 << 18, 1 << 15));
    return n;
  endfunction

  function automatic node_t noise_node();
    node_t n;
    n.start = 1'($urandom); n.node = 3'($urandom);
    n.rho = $urandom; n.mx = $urandom; n.my = $urandom;
    n.mxy = $urandom; n.mxx = $urandom; n.myy = $urandom;
    n.nx = rand_normal(); n.ny = rand_normal(); n.sj = 31'($urandom);
    return n;
  endfunction

  task automatic send_node(node_t n);
    if ($urandom_range(99) < snd_idle) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < snd_idle);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= pack_node(n);
    s_tuser  <= n.start;
    do @(posedge clk); while (!s_tready);
    board.note(n);
  endtask

  task automatic write_reg(logic idx, logic [30:0] v);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    board.write_reg(idx, v);
  endtask

  // Drop valid, wait for every expected beat, then let the block settle.
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (board.pending.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic run_directed();
    node_t n;
    n = rand_node(1'b1, 3'd0);
    n.rho = 65536; n.mx = 0; n.my = 0; n.mxy = 0; n.mxx = 0; n.myy = 0;
    n.nx = 18'sd65536; n.ny = '0; n.sj = 31'd65536;
    send_node(n);
    n.start = 1'b0; n.node = 3'd1; n.mx = 65536; n.my = -65536; n.mxy = 32768;
    n.mxx = 65536; n.myy = -65536; n.nx = -18'sd65536; n.ny = 18'sd65536;
    send_node(n);
    // zero density, with and without clearing
    n.rho = 0; send_node(n);
    n.start = 1'b1; send_node(n);
    n = rand_node(1'b0, 3'd0);
    n.rho = 32'h7FFFFFFF; n.mx = 32'h7FFFFFFF; n.my = 32'h7FFFFFFF; n.mxy = 32'h7FFFFFFF;
    n.mxx = 32'h7FFFFFFF; n.myy = 32'h7FFFFFFF; n.nx = 18'sd65536; n.ny = 18'sd65536;
    n.sj = 31'h7FFFFFFF;
    send_node(n); send_node(n);
    n.rho = 32'h80000000; n.mx = 32'h80000000; n.my = 32'h80000000; n.mxy = 32'h80000000;
    n.mxx = 32'h80000000; n.myy = 32'h80000000; n.nx = -18'sd65536; n.ny = -18'sd65536;
    send_node(n);
    n.rho = 1; n.mx = 32'h7FFFFFFF; n.my = 32'h80000000; send_node(n);
    n.rho = -1; n.node = 3'd1; send_node(n);
    // nodes beyond the order carry no weight
    for (int k = 2; k < 8; k++) send_node(rand_node(1'b0, 3'(k)));
    n = rand_node(1'b0, 3'd1); n.sj = '0; send_node(n);
    n = rand_node(1'b0, 3'd0); n.nx = '0; n.ny = '0; send_node(n);
    send_node(noise_node());
  endtask

  task automatic run_random(int count, int unsigned order);
    int sent;
    int unsigned top;
    sent = 0;
    top = (order >= 1 && order <= MAX_ORDER) ? order : $urandom_range(6, 1);
    while (sent < count) begin
      if ($urandom_range(4) == 0) begin
        send_node(noise_node());
        sent++;
      end else begin
        for (int k = 0; k <= top && sent < count; k++) begin
          // occasionally break the face off early
          if (k > 0 && $urandom_range(15) == 0) break;
          send_node(rand_node(k == 0, 3'(k)));
          sent++;
        end
      end
    end
  endtask

  localparam logic [30:0] PH_RT [0:7] = '{31'd65536, 31'h7FFFFFFF, 31'd0, 31'd98304,
                                           31'd33000, 31'd65536, 31'd131072, 31'd200000};
  localparam int unsigned PH_ORDER [0:7] = '{1, 6, 0, 3, 2, 7, 4, 5};

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    for (int p = 0; p < 8; p++) begin
      snd_idle = (p < 3) ? 35 : (p < 6) ? 71 : 0;
      rcv_idle = (p < 3) ? 71 : (p < 6) ? 35 : 0;
      write_reg(CFG_GAS_RT, PH_RT[p]);
      write_reg(CFG_POLY_ORDER, 31'(PH_ORDER[p]));
      if (p == 0) run_directed();
      if (p == 6) want_hold = 1;
      run_random(170, PH_ORDER[p]);
      drain();
    end
    if (board.fails == 0 && board.pending.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
